// ===== src/dgsp_pkg.sv =====
`timescale 1ns / 1ps
package dgsp_pkg;
  localparam int NODES = 8;
  localparam int NW = $clog2(NODES);
  localparam int EW = 2 * NW;
  localparam int DEPTH = NODES * NODES;
  localparam int LW = 16;
  localparam int WW = 8;
  localparam int ROUTE_MAX = 8;
  localparam int RW = $clog2(ROUTE_MAX + 1);
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
endpackage

// ===== src/dgsp_ram.sv =====
`timescale 1ns / 1ps
module dgsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/dense_graph_shortest_path.sv =====
`timescale 1ns / 1ps
// Edge write: both matrix directions are written, no result beats.
// A clearing pass over all NODES*NODES matrix entries follows reset before any item is taken.
// Search: per visited node, row reads through the one-read matrix port, then a
// minimum scan over all nodes; at most NODES rounds, then the walk back over the
// route nodes and one result beat per route node.
// Reset is synchronous and active high; it clears control state and starts the clear.
module dense_graph_shortest_path import dgsp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          kind,
  input  logic [2:0]    node_a,
  input  logic [2:0]    node_b,
  input  logic [WW-1:0] weight,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    route_node,
  output logic [LW-1:0] total_length,
  output logic          reachable,
  output logic          last
);
  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_WR2   = 9'b000000100,
    S_INIT  = 9'b000001000,
    S_RELAX = 9'b000010000,
    S_SCAN  = 9'b000100000,
    S_WALK  = 9'b001000000,
    S_EMIT  = 9'b010000000,
    S_ONE   = 9'b100000000
  } state_t;

  state_t state;
  logic [EW:0] cnt;
  logic [NW-1:0] src, dst, now, best_i;
  logic [WW-1:0] wr_w;
  logic [LW-1:0] len [NODES];
  logic [NW-1:0] pred [NODES];
  logic [NODES-1:0] vis, rch;
  logic found;
  logic [LW-1:0] least;
  logic [NW-1:0] stack [ROUTE_MAX];
  logic [RW-1:0] n, k;
  logic [NW-1:0] cur;

  logic we;
  logic [EW-1:0] waddr, raddr;
  logic [WW-1:0] wdata, rdata;

  dgsp_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_mat (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [NW-1:0] col, sc;
  logic [LW-1:0] cand;
  assign col = cnt[NW-1:0] - NW'(1);
  assign sc = cnt[NW-1:0];
  assign cand = len[now] + LW'(rdata);

  // Matrix port: clearing, edge writes and row reads.
  always_comb begin
    we = 1'b0;
    waddr = {node_a, node_b};
    wdata = weight;
    raddr = {now, cnt[NW-1:0]};
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        waddr = cnt[EW-1:0];
        wdata = '0;
      end
      S_IDLE: we = in_valid && kind == KIND_WRITE;
      S_WR2: begin
        we = 1'b1;
        waddr = {dst, src};
        wdata = wr_w;
      end
      default: ;
    endcase
  end

  assign in_stall = state != S_IDLE;
  assign out_valid = state == S_EMIT || state == S_ONE;

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      vis <= '0;
      rch <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == (EW + 1)'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          src <= node_a;
          dst <= node_b;
          wr_w <= weight;
          if (kind == KIND_WRITE) state <= S_WR2;
          else if (node_a == node_b) begin
            route_node <= node_b;
            total_length <= '0;
            reachable <= 1'b1;
            last <= 1'b1;
            state <= S_ONE;
          end else state <= S_INIT;
        end
        S_WR2: state <= S_IDLE;
        S_INIT: begin
          for (int i = 0; i < NODES; i++) begin
            len[i] <= '0;
            pred[i] <= NW'(i);
          end
          vis <= '0;
          rch <= NODES'(1) << src;
          now <= src;
          cnt <= '0;
          state <= S_RELAX;
        end
        S_RELAX: begin
          // Row data is registered and arrives in the cycle after its address.
          if (cnt == '0) vis[now] <= 1'b1;
          else if (!vis[col] && rdata != '0 && (!rch[col] || cand < len[col])) begin
            rch[col] <= 1'b1;
            len[col] <= cand;
            pred[col] <= now;
          end
          if (cnt == (EW + 1)'(NODES)) begin
            cnt <= '0;
            found <= 1'b0;
            state <= S_SCAN;
          end else cnt <= cnt + 1'b1;
        end
        S_SCAN: begin
          // One candidate per cycle; ties go to the higher index.
          if (!vis[sc] && rch[sc] && (!found || len[sc] <= least)) begin
            found <= 1'b1;
            least <= len[sc];
            best_i <= sc;
          end
          if (cnt == (EW + 1)'(NODES - 1)) begin
            cnt <= '0;
            if (!vis[sc] && rch[sc] && (!found || len[sc] <= least)) begin
              now <= sc;
              state <= S_RELAX;
            end else if (found) begin
              now <= best_i;
              state <= S_RELAX;
            end else if (!rch[dst]) begin
              route_node <= dst;
              total_length <= '0;
              reachable <= 1'b0;
              last <= 1'b1;
              state <= S_ONE;
            end else begin
              stack[0] <= dst;
              cur <= dst;
              n <= RW'(1);
              state <= S_WALK;
            end
          end else cnt <= cnt + 1'b1;
        end
        S_WALK: begin
          if (cur != src && n < RW'(ROUTE_MAX)) begin
            stack[n[NW-1:0]] <= pred[cur];
            cur <= pred[cur];
            n <= n + 1'b1;
          end else begin
            k <= n - 1'b1;
            route_node <= stack[n[NW-1:0] - NW'(1)];
            total_length <= len[dst];
            reachable <= 1'b1;
            last <= n == RW'(1);
            state <= S_EMIT;
          end
        end
        S_EMIT: if (!out_stall) begin
          if (k == '0) state <= S_IDLE;
          else begin
            route_node <= stack[k[NW-1:0] - NW'(1)];
            last <= k == RW'(1);
            k <= k - 1'b1;
          end
        end
        S_ONE: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
